/* hdl/assert_macros.svh */
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define ASSERT_NEXT(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* hdl/stt_pkg.sv */
package stt_pkg;

    typedef enum logic [3:0] {
        REQ_ADD_ONESHOT  = 4'd0,
        REQ_ADD_PERIODIC = 4'd1,
        REQ_REMOVE       = 4'd2,
        REQ_INCREASE     = 4'd3,
        REQ_DECREASE     = 4'd4,
        REQ_SET_DELAY    = 4'd5,
        REQ_RESTART      = 4'd6,
        REQ_SET_INTERVAL = 4'd7,
        REQ_QUERY_LEFT   = 4'd8,
        REQ_TICK         = 4'd9
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_FULL      = 3'd3,
        ST_ZERO      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_OUT,
        S_TSCAN,
        S_TOUT,
        S_TFIN,
        S_REARM
    } state_t;

    localparam int unsigned MAX_RESULTS = 16;
    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

endpackage

/* hdl/software_timer_table_top.sv */
// Timer table of SLOTS entries with a 64-bit tick counter. Each request takes
// one beat in and gives one result beat; a tick gives one beat per expired
// timer (earliest deadline first, ties by lowest slot, up to 16) or a single
// beat with fired low when nothing expired. One shared compare unit walks the
// slots one per cycle. A request first walks all slots to look up the id,
// then waits for the output register to be free, then applies the change and
// loads the result beat, after which the input is ready again. A tick scans
// all slots once, then for each expiry it reports waits for the output
// register and scans the slots again (every result is followed by a rescan,
// which also decides whether the held beat is the last), then walks all slots
// once more to re-arm or free the reported slots. A stalled result beat
// delays the block by the length of the stall. The input is not ready while a
// request or tick is in progress.
`include "assert_macros.svh"

module software_timer_table_top #(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_req_type,
    input  logic [63:0] s_timer_id,
    input  logic [31:0] s_amount,
    input  logic [31:0] s_interval_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [63:0] m_result_id,
    output logic        m_fired,
    output logic [31:0] m_time_left,
    output logic        m_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW = $clog2(stt_pkg::MAX_RESULTS + 1);

    // slot memories
    logic [63:0] key_mem    [SLOTS];
    logic        per_mem    [SLOTS];
    logic [63:0] start_mem  [SLOTS];
    logic [31:0] delay_mem  [SLOTS];
    logic [31:0] period_mem [SLOTS];
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SLOTS-1:0] taken_reg, taken_next;

    stt_pkg::state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [63:0] now_reg, now_next;
    logic [3:0]  req_reg;
    logic [63:0] id_reg;
    logic [31:0] amt_reg, ivl_reg;
    logic        s_fire;

    // scan results
    logic          hit_reg, hit_next, free_reg, free_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next, free_idx_reg, free_idx_next;
    logic          best_reg, best_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [63:0]   best_over_reg, best_over_next;
    logic [NW-1:0] n_reg, n_next;
    // expiry found but not yet sent, held until the next scan shows if it is last
    logic          pend_reg, pend_next;
    logic [63:0]   pend_key_reg, pend_key_next;

    // output register
    logic        ov_reg, ov_next;
    logic [2:0]  ost_reg, ost_next;
    logic [63:0] oid_reg, oid_next;
    logic        ofired_reg, ofired_next;
    logic [31:0] oleft_reg, oleft_next;
    logic        olast_reg, olast_next;

    // shared slot read port for the scans, addressed by the scan index
    logic [IW-1:0] ridx;
    logic [63:0]   r_key, r_start, r_el, r_over;
    logic [31:0]   r_delay;
    logic          r_exp;

    assign ridx    = idx_reg;
    assign r_key   = key_mem[ridx];
    assign r_start = start_mem[ridx];
    assign r_delay = delay_mem[ridx];
    assign r_el    = now_reg - r_start;
    assign r_exp   = r_el >= {32'd0, r_delay};
    assign r_over  = r_el - {32'd0, r_delay};

    assign s_ready = (state_reg == stt_pkg::S_IDLE);
    assign s_fire  = s_valid && s_ready;

    // request applied to hit slot
    logic [31:0] h_delay, h_period, new_ivl, new_amt;
    logic [63:0] h_el;
    logic [32:0] h_sum;
    assign h_delay  = delay_mem[hit_idx_reg];
    assign h_period = period_mem[hit_idx_reg];
    assign h_el     = now_reg - start_mem[hit_idx_reg];
    assign h_sum    = {1'b0, h_delay} + {1'b0, amt_reg};
    assign new_ivl  = (ivl_reg == 32'd0) ? 32'd1 : ivl_reg;
    assign new_amt  = (amt_reg == 32'd0) ? new_ivl : amt_reg;

    logic last_slot;
    assign last_slot = (idx_reg == IW'(SLOTS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stt_pkg::S_IDLE: begin
                if (s_fire) begin
                    state_next = (s_req_type == stt_pkg::REQ_TICK) ?
                        stt_pkg::S_TSCAN : stt_pkg::S_SCAN;
                end
            end
            stt_pkg::S_SCAN: if (last_slot) state_next = stt_pkg::S_OUT;
            stt_pkg::S_OUT: if (!ov_reg || m_ready) state_next = stt_pkg::S_APPLY;
            stt_pkg::S_APPLY: state_next = stt_pkg::S_IDLE;
            stt_pkg::S_TSCAN: if (last_slot) state_next = stt_pkg::S_TOUT;
            stt_pkg::S_TOUT: begin
                if (!ov_reg || m_ready) begin
                    if (best_reg && n_reg != NW'(stt_pkg::MAX_RESULTS))
                        state_next = stt_pkg::S_TFIN;
                    else state_next = stt_pkg::S_REARM;
                end
            end
            stt_pkg::S_TFIN: state_next = stt_pkg::S_TSCAN;
            stt_pkg::S_REARM: if (last_slot) state_next = stt_pkg::S_IDLE;
            default: state_next = stt_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        idx_next       = idx_reg;
        now_next       = now_reg;
        valid_next     = valid_reg;
        taken_next     = taken_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        best_over_next = best_over_reg;
        n_next         = n_reg;
        pend_next      = pend_reg;
        pend_key_next  = pend_key_reg;
        ov_next        = ov_reg && !m_ready;
        ost_next       = ost_reg;
        oid_next       = oid_reg;
        ofired_next    = ofired_reg;
        oleft_next     = oleft_reg;
        olast_next     = olast_reg;
        case (state_reg)
            stt_pkg::S_IDLE: begin
                idx_next  = '0;
                hit_next  = 1'b0;
                free_next = 1'b0;
                best_next = 1'b0;
                pend_next = 1'b0;
                n_next    = '0;
                if (s_fire && s_req_type == stt_pkg::REQ_TICK) begin
                    now_next   = now_reg + 64'd1;
                    taken_next = '0;
                end
            end
            stt_pkg::S_SCAN: begin
                if (valid_reg[ridx] && r_key == id_reg && !hit_reg) begin
                    hit_next     = 1'b1;
                    hit_idx_next = ridx;
                end
                if (!valid_reg[ridx] && !free_reg) begin
                    free_next     = 1'b1;
                    free_idx_next = ridx;
                end
                idx_next = idx_reg + IW'(1);
            end
            stt_pkg::S_APPLY: begin
                ov_next     = 1'b1;
                ost_next    = stt_pkg::ST_OK;
                oid_next    = id_reg;
                ofired_next = 1'b0;
                oleft_next  = '0;
                olast_next  = 1'b1;
                case (req_reg) inside
                    stt_pkg::REQ_ADD_ONESHOT, stt_pkg::REQ_ADD_PERIODIC: begin
                        if (hit_reg) ost_next = stt_pkg::ST_EXISTS;
                        else if (!free_reg) ost_next = stt_pkg::ST_FULL;
                        else valid_next[free_idx_reg] = 1'b1;
                    end
                    [stt_pkg::REQ_REMOVE:stt_pkg::REQ_QUERY_LEFT]: begin
                        if ((req_reg == stt_pkg::REQ_INCREASE ||
                             req_reg == stt_pkg::REQ_DECREASE) && amt_reg == 32'd0)
                            ost_next = stt_pkg::ST_ZERO;
                        else if (!hit_reg) ost_next = stt_pkg::ST_NOT_FOUND;
                        else if (req_reg == stt_pkg::REQ_REMOVE)
                            valid_next[hit_idx_reg] = 1'b0;
                        else if (req_reg == stt_pkg::REQ_QUERY_LEFT &&
                                 h_el < {32'd0, h_delay})
                            oleft_next = h_delay - h_el[31:0];
                    end
                    default: ;
                endcase
            end
            stt_pkg::S_TSCAN: begin
                if (valid_reg[ridx] && !taken_reg[ridx] && r_exp &&
                    (!best_reg || r_over > best_over_reg)) begin
                    best_next      = 1'b1;
                    best_idx_next  = ridx;
                    best_over_next = r_over;
                end
                idx_next = idx_reg + IW'(1);
            end
            stt_pkg::S_TOUT: begin
                if (!ov_reg || m_ready) begin
                    // send the held expiry, or the empty beat when nothing expired
                    if (pend_reg || !best_reg) begin
                        ov_next     = 1'b1;
                        ost_next    = stt_pkg::ST_OK;
                        ofired_next = pend_reg;
                        oleft_next  = '0;
                        oid_next    = pend_reg ? pend_key_reg : 64'd0;
                        olast_next  = !best_reg ||
                                      n_reg == NW'(stt_pkg::MAX_RESULTS);
                    end
                    pend_next = 1'b0;
                    if (best_reg && n_reg != NW'(stt_pkg::MAX_RESULTS)) begin
                        taken_next[best_idx_reg] = 1'b1;
                        pend_next     = 1'b1;
                        pend_key_next = key_mem[best_idx_reg];
                        n_next        = n_reg + NW'(1);
                    end
                    idx_next = '0;
                end
            end
            stt_pkg::S_TFIN: begin
                best_next = 1'b0;
            end
            stt_pkg::S_REARM: begin
                if (taken_reg[ridx] && !per_mem[ridx]) valid_next[ridx] = 1'b0;
                idx_next = idx_reg + IW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stt_pkg::S_IDLE;
            valid_reg <= '0;
            now_reg   <= '0;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            n_reg     <= '0;
            best_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            taken_reg <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            now_reg   <= now_next;
            ov_reg    <= ov_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            best_reg  <= best_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            pend_reg  <= pend_next;
            taken_reg <= taken_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        best_idx_reg  <= best_idx_next;
        best_over_reg <= best_over_next;
        pend_key_reg  <= pend_key_next;
        ost_reg       <= ost_next;
        oid_reg       <= oid_next;
        ofired_reg    <= ofired_next;
        oleft_reg     <= oleft_next;
        olast_reg     <= olast_next;
        if (s_fire) begin
            req_reg <= s_req_type;
            id_reg  <= s_timer_id;
            amt_reg <= s_amount;
            ivl_reg <= s_interval_value;
        end
    end

    // slot memory writes
    always_ff @(posedge aclk) begin
        if (state_reg == stt_pkg::S_APPLY) begin
            if ((req_reg == stt_pkg::REQ_ADD_ONESHOT || req_reg == stt_pkg::REQ_ADD_PERIODIC)
                && !hit_reg && free_reg) begin
                key_mem[free_idx_reg]   <= id_reg;
                start_mem[free_idx_reg] <= now_reg;
                per_mem[free_idx_reg]   <= (req_reg == stt_pkg::REQ_ADD_PERIODIC);
                period_mem[free_idx_reg] <=
                    (req_reg == stt_pkg::REQ_ADD_PERIODIC) ? new_ivl : 32'd0;
                delay_mem[free_idx_reg] <=
                    (req_reg == stt_pkg::REQ_ADD_PERIODIC) ? new_amt : amt_reg;
            end else if (hit_reg) begin
                case (req_reg)
                    stt_pkg::REQ_INCREASE: if (amt_reg != 32'd0)
                        delay_mem[hit_idx_reg] <= h_sum[32] ? stt_pkg::ALL_ONES32
                                                            : h_sum[31:0];
                    stt_pkg::REQ_DECREASE: if (amt_reg != 32'd0)
                        delay_mem[hit_idx_reg] <= (amt_reg < h_delay) ?
                                                  h_delay - amt_reg : 32'd0;
                    stt_pkg::REQ_SET_DELAY: delay_mem[hit_idx_reg] <= amt_reg;
                    stt_pkg::REQ_RESTART: start_mem[hit_idx_reg] <= now_reg;
                    stt_pkg::REQ_SET_INTERVAL: begin
                        if (per_mem[hit_idx_reg] && h_period != ivl_reg) begin
                            if (h_delay == h_period) delay_mem[hit_idx_reg] <= ivl_reg;
                            period_mem[hit_idx_reg] <= ivl_reg;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (state_reg == stt_pkg::S_REARM) begin
            if (taken_reg[ridx] && per_mem[ridx]) begin
                delay_mem[ridx] <= period_mem[ridx];
                start_mem[ridx] <= now_reg;
            end
        end
    end

    assign m_valid     = ov_reg;
    assign m_status    = ost_reg;
    assign m_result_id = oid_reg;
    assign m_fired     = ofired_reg;
    assign m_time_left = oleft_reg;
    assign m_last      = olast_reg;

    `ASSERT_IMPL(a_busy_not_ready, aclk, aresetn,
        !(state_reg != stt_pkg::S_IDLE && s_ready), "ready while busy")
    `ASSERT_NEXT(a_tick_advances, aclk, aresetn,
        s_fire && s_req_type == stt_pkg::REQ_TICK, now_reg == $past(now_reg) + 64'd1,
        "tick did not advance time")
    `ASSERT_IMPL(a_fire_no_left, aclk, aresetn,
        !(m_valid && m_fired && m_time_left != 32'd0), "expiry with time left")

endmodule

/* test/tb_software_timer_table_top.sv */
module tb_software_timer_table_top;

    localparam int NSLOT = 16;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic [3:0]  req;
        logic [63:0] id;
        logic [31:0] amt;
        logic [31:0] ivl;
    } beat_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] id;
        logic        fired;
        logic [31:0] left;
        logic        last;
    } beat_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_req_type = '0;
    logic [63:0] s_timer_id = '0;
    logic [31:0] s_amount = '0;
    logic [31:0] s_interval_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [63:0] m_result_id;
    logic        m_fired;
    logic [31:0] m_time_left;
    logic        m_last;

    software_timer_table_top #(.SLOTS(NSLOT)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_timer_id(s_timer_id), .s_amount(s_amount),
        .s_interval_value(s_interval_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_result_id(m_result_id), .m_fired(m_fired),
        .m_time_left(m_time_left), .m_last(m_last)
    );

    always #4 aclk = ~aclk;

    // timer table mirror
    logic        t_used [NSLOT];
    logic [63:0] t_key [NSLOT];
    logic        t_per [NSLOT];
    logic [63:0] t_start [NSLOT];
    logic [31:0] t_delay [NSLOT];
    logic [31:0] t_period [NSLOT];
    logic [63:0] tick_count;

    beat_in_t  pending_reqs[$];
    beat_out_t expected_results[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_off = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;
    logic [63:0] id_pool [8];

    function automatic int lookup(logic [63:0] id);
        for (int i = 0; i < NSLOT; i++)
            if (t_used[i] && t_key[i] == id) return i;
        return -1;
    endfunction

    function automatic void push_result(logic [2:0] st, logic [63:0] id, logic f,
                                        logic [31:0] lft, logic lst);
        beat_out_t r;
        r.status = st; r.id = id; r.fired = f; r.left = lft; r.last = lst;
        expected_results.push_back(r);
    endfunction

    function automatic void advance_tick();
        bit          taken [NSLOT];
        int          n;
        int          best;
        logic [63:0] best_over;
        logic [63:0] el;
        n = 0;
        tick_count = tick_count + 1;
        for (int i = 0; i < NSLOT; i++) taken[i] = 0;
        while (n < stt_pkg::MAX_RESULTS) begin
            best = -1;
            best_over = 0;
            for (int i = 0; i < NSLOT; i++) begin
                if (!t_used[i] || taken[i]) continue;
                el = tick_count - t_start[i];
                if (el < {32'd0, t_delay[i]}) continue;
                if (best < 0 || el - t_delay[i] > best_over) begin
                    best = i;
                    best_over = el - t_delay[i];
                end
            end
            if (best < 0) break;
            taken[best] = 1;
            push_result(stt_pkg::ST_OK, t_key[best], 1'b1, '0, 1'b0);
            n++;
        end
        for (int i = 0; i < NSLOT; i++) begin
            if (!taken[i]) continue;
            if (t_per[i]) begin
                t_delay[i] = t_period[i];
                t_start[i] = tick_count;
            end else begin
                t_used[i] = 0;
            end
        end
        if (n == 0) push_result(stt_pkg::ST_OK, '0, 1'b0, '0, 1'b1);
        else expected_results[$].last = 1'b1;
    endfunction

    function automatic void predict_request(beat_in_t b);
        logic [2:0]  st;
        logic [31:0] lft;
        logic [31:0] amt;
        logic [31:0] ivl;
        logic [63:0] el;
        logic [32:0] sum;
        int          s;
        st = stt_pkg::ST_OK; lft = '0; amt = b.amt; ivl = b.ivl;
        if (b.req == stt_pkg::REQ_TICK) begin
            advance_tick();
            return;
        end
        if (b.req == stt_pkg::REQ_ADD_ONESHOT || b.req == stt_pkg::REQ_ADD_PERIODIC) begin
            if (lookup(b.id) >= 0) st = stt_pkg::ST_EXISTS;
            else begin
                s = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (!t_used[i]) begin s = i; break; end
                if (s < 0) st = stt_pkg::ST_FULL;
                else begin
                    if (b.req == stt_pkg::REQ_ADD_PERIODIC) begin
                        if (ivl == 0) ivl = 1;
                        if (amt == 0) amt = ivl;
                        t_per[s] = 1; t_period[s] = ivl;
                    end else begin
                        t_per[s] = 0; t_period[s] = 0;
                    end
                    t_used[s] = 1; t_key[s] = b.id;
                    t_start[s] = tick_count; t_delay[s] = amt;
                end
            end
        end else if (b.req >= stt_pkg::REQ_REMOVE && b.req <= stt_pkg::REQ_QUERY_LEFT) begin
            if ((b.req == stt_pkg::REQ_INCREASE || b.req == stt_pkg::REQ_DECREASE) &&
                amt == 0) st = stt_pkg::ST_ZERO;
            else begin
                s = lookup(b.id);
                if (s < 0) st = stt_pkg::ST_NOT_FOUND;
                else case (b.req)
                    stt_pkg::REQ_REMOVE: t_used[s] = 0;
                    stt_pkg::REQ_INCREASE: begin
                        sum = {1'b0, t_delay[s]} + amt;
                        t_delay[s] = (sum >= {1'b0, stt_pkg::ALL_ONES32}) ?
                                     stt_pkg::ALL_ONES32 : sum[31:0];
                    end
                    stt_pkg::REQ_DECREASE:
                        t_delay[s] = (amt < t_delay[s]) ? t_delay[s] - amt : '0;
                    stt_pkg::REQ_SET_DELAY: t_delay[s] = amt;
                    stt_pkg::REQ_RESTART: t_start[s] = tick_count;
                    stt_pkg::REQ_SET_INTERVAL: begin
                        if (t_per[s] && t_period[s] != ivl) begin
                            if (t_delay[s] == t_period[s]) t_delay[s] = ivl;
                            t_period[s] = ivl;
                        end
                    end
                    default: begin
                        el = tick_count - t_start[s];
                        lft = (el >= {32'd0, t_delay[s]}) ? '0 : t_delay[s] - el[31:0];
                    end
                endcase
            end
        end
        push_result(st, b.id, 1'b0, lft, 1'b1);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_request({s_req_type, s_timer_id, s_amount,
                                                     s_interval_value});
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    beat_in_t b;
                    b = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= b.req; s_timer_id <= b.id;
                    s_amount <= b.amt; s_interval_value <= b.ivl;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                beat_out_t want;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat id=%h status=%0d",
                                 m_result_id, m_status);
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== m_status || want.id !== m_result_id ||
                        want.fired !== m_fired || want.left !== m_time_left ||
                        want.last !== m_last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: want st=%0d id=%h f=%b left=%0d last=%b,",
                                      " got st=%0d id=%h f=%b left=%0d last=%b"},
                                     want.status, want.id, want.fired, want.left,
                                     want.last, m_status, m_result_id, m_fired,
                                     m_time_left, m_last);
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("** software_timer_table_top: FAILED **");
            $finish;
        end
    end

    function automatic void add_req(logic [3:0] r, logic [63:0] id, logic [31:0] a,
                                    logic [31:0] v);
        beat_in_t b;
        b.req = r; b.id = id; b.amt = a; b.ivl = v;
        pending_reqs.push_back(b);
    endfunction

    function automatic logic [31:0] rand_small();
        case ($urandom_range(9))
            0: return '0;
            1: return stt_pkg::ALL_ONES32;
            2: return $urandom();
            default: return $urandom_range(6);
        endcase
    endfunction

    function automatic void queue_random(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 35)
                add_req(stt_pkg::REQ_TICK, {$urandom(), $urandom()}, $urandom(),
                        $urandom());
            else if (k < 55)
                add_req($urandom_range(1) ? stt_pkg::REQ_ADD_PERIODIC
                                          : stt_pkg::REQ_ADD_ONESHOT,
                        id_pool[$urandom_range(7)], rand_small(), rand_small());
            else if (k < 95)
                add_req(4'($urandom_range(stt_pkg::REQ_REMOVE, stt_pkg::REQ_QUERY_LEFT)),
                        $urandom_range(9) == 0 ? {$urandom(), $urandom()}
                                               : id_pool[$urandom_range(7)],
                        rand_small(), rand_small());
            else add_req(4'($urandom_range(10, 15)), {$urandom(), $urandom()}, $urandom(),
                         $urandom());
        end
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) t_used[i] = 0;
        tick_count = '0;
        for (int i = 0; i < 8; i++) id_pool[i] = {$urandom(), $urandom()};
        id_pool[0] = '0;
        id_pool[1] = '1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every request kind, field extremes, saturation and floors
        add_req(stt_pkg::REQ_TICK, '0, '0, '0);
        add_req(stt_pkg::REQ_ADD_ONESHOT, '0, 32'd2, '0);
        add_req(stt_pkg::REQ_ADD_ONESHOT, '0, 32'd2, '0);
        add_req(stt_pkg::REQ_ADD_PERIODIC, '1, '0, '0);
        add_req(stt_pkg::REQ_ADD_PERIODIC, 64'h5a5a, '0, 32'd3);
        add_req(stt_pkg::REQ_INCREASE, '1, '0, '0);
        add_req(stt_pkg::REQ_INCREASE, 64'h5a5a, stt_pkg::ALL_ONES32, '0);
        add_req(stt_pkg::REQ_DECREASE, 64'h5a5a, '0, '0);
        add_req(stt_pkg::REQ_DECREASE, 64'h5a5a, stt_pkg::ALL_ONES32, '0);
        add_req(stt_pkg::REQ_QUERY_LEFT, '0, '0, '0);
        add_req(stt_pkg::REQ_TICK, '0, '0, '0);
        add_req(stt_pkg::REQ_TICK, '0, '0, '0);
        add_req(stt_pkg::REQ_QUERY_LEFT, '1, '0, '0);
        add_req(stt_pkg::REQ_SET_DELAY, '1, 32'd5, '0);
        add_req(stt_pkg::REQ_SET_INTERVAL, '1, '0, 32'd5);
        add_req(stt_pkg::REQ_SET_INTERVAL, '1, '0, '0);
        add_req(stt_pkg::REQ_RESTART, '1, '0, '0);
        add_req(stt_pkg::REQ_REMOVE, 64'h77, '0, '0);
        add_req(stt_pkg::REQ_REMOVE, 64'h5a5a, '0, '0);
        add_req(4'hf, '1, stt_pkg::ALL_ONES32, stt_pkg::ALL_ONES32);
        // fill the table past full, all expiring together
        for (int i = 0; i < 17; i++)
            add_req(stt_pkg::REQ_ADD_PERIODIC, 64'h1000 + i, 32'd1, '0);
        add_req(stt_pkg::REQ_TICK, '0, '0, '0);
        add_req(stt_pkg::REQ_TICK, '0, '0, '0);
        for (int i = 0; i < 17; i++) add_req(stt_pkg::REQ_REMOVE, 64'h1000 + i, '0, '0);
        add_req(stt_pkg::REQ_REMOVE, '1, '0, '0);
        drain();

        recv_stall_pct = 0; send_idle_pct = 0;
        queue_random(100); drain();
        send_idle_pct = 49;
        queue_random(100); drain();
        send_idle_pct = 0; recv_stall_pct = 49;
        queue_random(50);
        hold_off = 400;
        queue_random(50); drain();
        send_idle_pct = 21; recv_stall_pct = 21;
        queue_random(80); drain();

        repeat (200) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("** software_timer_table_top: PASSED **");
        else
            $display("** software_timer_table_top: FAILED **");
        $finish;
    end
endmodule

/* files.f */
+incdir+hdl
hdl/stt_pkg.sv
hdl/software_timer_table_top.sv
test/tb_software_timer_table_top.sv
